### src/paper_and_mark_sensor_qualifier_defines.svh
// assertion macros for the sensor qualifier
`ifndef PAPER_AND_MARK_SENSOR_QUALIFIER_DEFINES_SVH
`define PAPER_AND_MARK_SENSOR_QUALIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define PSQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("psq assertion failed");
`define PSQ_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("psq assertion failed");
`else
`define PSQ_ASSERT(name, prop)
`define PSQ_ASSERT_ALWAYS(name, prop)
`endif

`endif

### src/psq_pkg.sv
`timescale 1ns / 1ps
package psq_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned AVG_W      = 12;
  localparam int unsigned SETTLE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAPER_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAPER_SETTLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_SETTLE  = 3'd4;

  localparam logic [AVG_W-1:0]    PAPER_THR_RST    = 12'h130;
  localparam logic [AVG_W-1:0]    MARK_LOW_RST     = 12'h130;
  localparam logic [AVG_W-1:0]    MARK_HIGH_RST    = 12'h200;
  localparam logic [SETTLE_W-1:0] PAPER_SETTLE_RST = 4'd2;
  localparam logic [SETTLE_W-1:0] MARK_SETTLE_RST  = 4'd1;

  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_RISE = 2'd1,
    EVT_FALL = 2'd2
  } evt_e;

  typedef struct packed {
    logic step;
    logic load;
    logic now;
  } dbc_ctrl_t;

  typedef struct packed {
    logic flag;
    evt_e evt;
  } dbc_stat_t;

endpackage

### src/psq_ram.sv
`timescale 1ns / 1ps
module psq_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 10,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/psq_debounce.sv
`timescale 1ns / 1ps
module psq_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psq_pkg::dbc_ctrl_t            ctrl_i,
  input  logic [psq_pkg::SETTLE_W-1:0]  settle_i,
  output psq_pkg::dbc_stat_t            stat_o
);
  import psq_pkg::*;

  logic                seen_q, seen_d;
  logic                flag_q, flag_d;
  logic [SETTLE_W-1:0] count_q, count_d;
  logic [SETTLE_W-1:0] settle_eff;
  evt_e                evt;

  assign settle_eff = (settle_i == '0) ? SETTLE_W'(1) : settle_i;

  always_comb begin
    seen_d  = seen_q;
    flag_d  = flag_q;
    count_d = count_q;
    evt     = EVT_NONE;
    if (ctrl_i.load) begin
      seen_d  = ctrl_i.now;
      flag_d  = ctrl_i.now;
      count_d = '0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.now != seen_q) begin
        seen_d  = ctrl_i.now;
        count_d = settle_eff;
      end else if (count_q != '0) begin
        count_d = count_q - SETTLE_W'(1);
        if ((count_d == '0) && (flag_q != ctrl_i.now)) begin
          flag_d = ctrl_i.now;
          evt    = ctrl_i.now ? EVT_RISE : EVT_FALL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      flag_q  <= 1'b0;
      count_q <= '0;
    end else begin
      seen_q  <= seen_d;
      flag_q  <= flag_d;
      count_q <= count_d;
    end
  end

  assign stat_o.flag = flag_d;
  assign stat_o.evt  = evt;

endmodule

### src/paper_and_mark_sensor_qualifier.sv
// a start, or a tick once running, passes the second stage and the output register
// throughput: one item per cycle; a start or running tick stalls only while a result waits
// a sample reads its old ring entry in the accept cycle and writes it back in the next cycle
// reset: asynchronous, clears control state, sum, pointer and ring valid bits;
// config registers return to defaults, no clearing pass
`timescale 1ns / 1ps
`include "paper_and_mark_sensor_qualifier_defines.svh"
module paper_and_mark_sensor_qualifier #(
  parameter int unsigned SAMPLE_COUNT = 10,
  parameter int unsigned ADC_BITS     = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [psq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [psq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      opcode_i,
  input  logic [psq_pkg::SAMPLE_W-1:0]    sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            paper_present_o,
  output logic                            mark_present_o,
  output logic                            paper_now_o,
  output logic [1:0]                      paper_event_o,
  output logic [1:0]                      mark_event_o,
  output logic [psq_pkg::AVG_W-1:0]       average_o
);
  import psq_pkg::*;

  localparam int unsigned PTR_W   = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int unsigned SUM_W   = $clog2(SAMPLE_COUNT * ((2 ** ADC_BITS) - 1) + 1);
  localparam int unsigned DIV_K   = SUM_W + PTR_W;
  localparam int unsigned MUL_W   = DIV_K + 2;
  localparam int unsigned PROD_W  = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV_M = MUL_W'((2 ** DIV_K) / SAMPLE_COUNT + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SAMPLE_COUNT - 1);

  // configuration
  logic [AVG_W-1:0]    paper_thr_q, mark_low_q, mark_high_q;
  logic [SETTLE_W-1:0] paper_settle_q, mark_settle_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paper_thr_q    <= PAPER_THR_RST;
      mark_low_q     <= MARK_LOW_RST;
      mark_high_q    <= MARK_HIGH_RST;
      paper_settle_q <= PAPER_SETTLE_RST;
      mark_settle_q  <= MARK_SETTLE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PAPER_THR:    paper_thr_q    <= cfg_data_i;
        CFG_MARK_LOW:     mark_low_q     <= cfg_data_i;
        CFG_MARK_HIGH:    mark_high_q    <= cfg_data_i;
        CFG_PAPER_SETTLE: paper_settle_q <= cfg_data_i[SETTLE_W-1:0];
        CFG_MARK_SETTLE:  mark_settle_q  <= cfg_data_i[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // accept stage
  logic                    in_acc, rd_en;
  logic [ADC_BITS-1:0]     sample_adc;
  logic [PTR_W-1:0]        ptr_q;
  logic [SAMPLE_COUNT-1:0] ring_valid_q;

  // second stage
  logic                s1_valid_q;
  logic [1:0]          s1_op_q;
  logic [ADC_BITS-1:0] s1_sample_q;
  logic [PTR_W-1:0]    s1_addr_q;
  logic                s1_rd_valid_q;
  logic                s1_fwd_q;
  logic [ADC_BITS-1:0] s1_fwd_data_q;
  logic                s1_has_res, s1_adv, ram_we;
  logic [ADC_BITS-1:0] ram_rdata, old_sample;

  logic [SUM_W-1:0]  sum_q;
  logic              running_q;
  logic [PROD_W-1:0] prod;
  logic [AVG_W-1:0]  avg;
  logic              pnow, mnow;

  assign sample_adc = ADC_BITS'(sample_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_en      = in_acc && (opcode_i == OP_SAMPLE);

  assign s1_has_res = (s1_op_q == OP_START) || ((s1_op_q == OP_TICK) && running_q);
  assign s1_adv     = s1_valid_q && (!s1_has_res || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign ram_we     = s1_adv && (s1_op_q == OP_SAMPLE);

  psq_ram #(
    .WIDTH (ADC_BITS),
    .DEPTH (SAMPLE_COUNT),
    .AW    (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_sample_q),
    .re_i    (rd_en),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign old_sample = s1_fwd_q      ? s1_fwd_data_q :
                      s1_rd_valid_q ? ram_rdata     : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      ptr_q        <= '0;
      ring_valid_q <= '0;
      sum_q        <= '0;
      running_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (rd_en) begin
        ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
      end
      if (ram_we) begin
        ring_valid_q[s1_addr_q] <= 1'b1;
        sum_q <= sum_q - SUM_W'(old_sample) + SUM_W'(s1_sample_q);
      end
      if (s1_adv && (s1_op_q == OP_START)) begin
        running_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q       <= opcode_i;
      s1_sample_q   <= sample_adc;
      s1_addr_q     <= ptr_q;
      s1_rd_valid_q <= ring_valid_q[ptr_q];
      s1_fwd_q      <= ram_we && (s1_addr_q == ptr_q);
      s1_fwd_data_q <= s1_sample_q;
    end
  end

  // average by reciprocal multiply
  assign prod = PROD_W'(sum_q) * PROD_W'(DIV_M);
  assign avg  = AVG_W'(prod[DIV_K +: ADC_BITS]);
  assign pnow = !(avg < paper_thr_q);
  assign mnow = (avg < mark_high_q) && (avg > mark_low_q);

  dbc_ctrl_t paper_ctrl, mark_ctrl;
  dbc_stat_t paper_stat, mark_stat;

  assign paper_ctrl.step = s1_adv && (s1_op_q == OP_TICK) && running_q;
  assign paper_ctrl.load = s1_adv && (s1_op_q == OP_START);
  assign paper_ctrl.now  = pnow;
  assign mark_ctrl.step  = paper_ctrl.step;
  assign mark_ctrl.load  = 1'b0;
  assign mark_ctrl.now   = mnow;

  psq_debounce u_paper_dbc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (paper_ctrl),
    .settle_i (paper_settle_q),
    .stat_o   (paper_stat)
  );

  psq_debounce u_mark_dbc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mark_ctrl),
    .settle_i (mark_settle_q),
    .stat_o   (mark_stat)
  );

  // output register
  logic             out_valid_q;
  logic             paper_present_q, mark_present_q, paper_now_q;
  logic [1:0]       paper_event_q, mark_event_q;
  logic [AVG_W-1:0] average_q;
  logic             res_load;

  assign res_load = s1_adv && s1_has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      paper_present_q <= paper_stat.flag;
      mark_present_q  <= mark_stat.flag;
      paper_now_q     <= pnow;
      paper_event_q   <= paper_stat.evt;
      mark_event_q    <= mark_stat.evt;
      average_q       <= avg;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign paper_present_o = paper_present_q;
  assign mark_present_o  = mark_present_q;
  assign paper_now_o     = paper_now_q;
  assign paper_event_o   = paper_event_q;
  assign mark_event_o    = mark_event_q;
  assign average_o       = average_q;

  `PSQ_ASSERT(a_fwd_only_sample, s1_fwd_q |-> (s1_valid_q && (s1_op_q == OP_SAMPLE)))
  `PSQ_ASSERT(a_ptr_step, rd_en |=> (ptr_q == (($past(ptr_q) == PTR_LAST) ? '0 : $past(ptr_q) + PTR_W'(1))))
  `PSQ_ASSERT_ALWAYS(a_stall_blocks_input, (s1_valid_q && !s1_adv) |-> !in_ready_o)

endmodule
